[rtl/core/lss_pkg.sv]
`default_nettype none

package lss_pkg;

  // sizing
  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned LINE_LIMIT  = 4096;
  localparam int unsigned PTR_W       = $clog2(PATTERN_MAX);
  localparam int unsigned CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned LINE_W      = $clog2(LINE_LIMIT) + 1;
  localparam int unsigned WIN_W       = PATTERN_MAX * 8;

  // fixed field widths
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned PLEN_W   = 7;

  // special characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // command codes
  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_END     = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  // register indexes
  typedef enum logic [0:0] {
    REG_PATTERN_LENGTH = 1'b0,
    REG_FIRST_LINE     = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e             command;
    logic [7:0]       byte_value;
    logic [PTR_W-1:0] pattern_position;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] line_index;
    logic             line_matched;
    logic             first_hit;
    logic             line_empty;
  } out_t;

  // per cell control
  typedef struct packed {
    logic shift;
    logic pat_we;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/lss_cell.sv]
`default_nettype none

module lss_cell
  import lss_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [7:0] shift_in_i,
  input  wire logic [7:0] pat_byte_i,
  input  wire logic [7:0] aligned_i,
  output logic      [7:0] win_o,
  output logic            eq_o
);

  logic [7:0] win_q;
  logic [7:0] pat_q;

  // window byte, handed on to the next cell on every visible byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q <= shift_in_i;
    end
  end

  // pattern byte held by this cell
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_we) begin
      pat_q <= pat_byte_i;
    end
  end

  // compare against the text byte lined up with this pattern slot
  assign eq_o  = (aligned_i == pat_q);
  assign win_o = win_q;

endmodule

`default_nettype wire

[rtl/core/line_substring_search.sv]
`default_nettype none

// Line substring search.
// The input channel (in_valid_i / in_stall_o / in_data_i) takes one command
// beat per cycle: pattern byte loads, text bytes, end of text and restart.
// Text is split into lines at newline; a carriage return or a zero byte
// hides the rest of its line. When a line ends, one beat leaves on the
// output channel (out_valid_o / out_stall_i / out_data_o) with the line
// index and the matched, first hit and empty flags.
// Throughput is one input beat per cycle while in_stall_o is low: the window
// compare against all pattern slots runs across the cell row in the cycle the
// byte arrives. The result leaves from the output register in the cycle after
// the ending newline or end-of-text beat.
// The config channel (cfg_valid_i / cfg_ready_o) is always ready and writes
// pattern_length (index 0) or the lowest line index for a first hit
// (index 1); write it only when idle.
// Reset clears the text state, the registers and the output; pattern bytes
// must be loaded before use. While the receiver stalls a waiting result,
// the input is stalled too; otherwise input flows while a result waits.
// After 4096 lines no more results are produced until an end or restart beat.
module line_substring_search
  import lss_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire reg_e             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  logic [PLEN_W-1:0] plen_q;
  logic [IDX_W-1:0]  start_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LINE_W-1:0] line_q;
  logic              hit_q, cut_q, pending_q, reported_q;
  logic              out_valid_q;
  out_t              out_data_q;

  logic [CNT_W-1:0]  plen_eff;
  logic [CNT_W-1:0]  shift_amt;
  logic              accept, below_limit, is_text, is_end, is_restart, is_pat;
  logic              is_nl, is_hide, take, finish_nl, finish_end, finish;
  logic              matched, first, hit_now, all_eq;

  logic [7:0]             win   [PATTERN_MAX];
  logic [7:0]             win_nx[PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq, len_mask;
  logic [WIN_W-1:0]       rev, aligned;
  cell_ctrl_t             ctrl  [PATTERN_MAX];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= '0;
      start_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_LENGTH: plen_q  <= cfg_data_i[PLEN_W-1:0];
        REG_FIRST_LINE:     start_q <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign plen_eff  = (plen_q > CNT_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX) : plen_q;
  assign shift_amt = CNT_W'(PATTERN_MAX) - plen_eff;

  // command decode
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign below_limit = line_q < LINE_W'(LINE_LIMIT);
  assign is_pat      = accept & (in_data_i.command == CMD_PATTERN);
  assign is_text     = accept & (in_data_i.command == CMD_TEXT) & below_limit;
  assign is_end      = accept & (in_data_i.command == CMD_END);
  assign is_restart  = accept & (in_data_i.command == CMD_RESTART);
  assign is_nl       = in_data_i.byte_value == CH_NEWLINE;
  assign is_hide     = (in_data_i.byte_value == CH_RETURN) ||
                       (in_data_i.byte_value == CH_NUL);
  assign take        = is_text & ~is_nl & ~is_hide & ~cut_q;
  assign finish_nl   = is_text & is_nl;
  assign finish_end  = is_end & pending_q & below_limit;
  assign finish      = finish_nl | finish_end;

  // cell row: window shifts by one byte per visible text byte
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign win_nx[j] = in_data_i.byte_value;
    end else begin : g_body
      assign win_nx[j] = win[j-1];
    end
    assign rev[j*8 +: 8] = win_nx[PATTERN_MAX-1-j];
    assign len_mask[j]   = CNT_W'(j) < plen_eff;
    assign ctrl[j].shift  = take;
    assign ctrl[j].pat_we = is_pat & (in_data_i.pattern_position == PTR_W'(j));

    lss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[j]),
      .shift_in_i (win_nx[j]),
      .pat_byte_i (in_data_i.byte_value),
      .aligned_i  (aligned[j*8 +: 8]),
      .win_o      (win[j]),
      .eq_o       (eq[j])
    );
  end

  // line up the newest plen bytes with pattern slots 0 .. plen-1
  assign aligned = rev >> {shift_amt, 3'b000};
  assign all_eq  = &(eq | ~len_mask);

  assign count_d = (count_q < CNT_W'(PATTERN_MAX)) ? count_q + CNT_W'(1) : count_q;
  assign hit_now = take & (plen_eff != '0) & (count_d >= plen_eff) & all_eq;

  assign matched = hit_q | (plen_eff == '0);
  assign first   = matched & ~reported_q & (line_q >= {1'b0, start_q});

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      line_q     <= '0;
      hit_q      <= 1'b0;
      cut_q      <= 1'b0;
      pending_q  <= 1'b0;
      reported_q <= 1'b0;
    end else begin
      priority if (is_end || is_restart) begin
        count_q    <= '0;
        line_q     <= '0;
        hit_q      <= 1'b0;
        cut_q      <= 1'b0;
        pending_q  <= 1'b0;
        reported_q <= 1'b0;
      end else if (finish_nl) begin
        count_q    <= '0;
        line_q     <= line_q + LINE_W'(1);
        hit_q      <= 1'b0;
        cut_q      <= 1'b0;
        pending_q  <= 1'b0;
        reported_q <= reported_q | first;
      end else if (is_text) begin
        pending_q <= 1'b1;
        if (is_hide) begin
          cut_q <= 1'b1;
        end
        if (take) begin
          count_q <= count_d;
        end
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end else begin
        count_q <= count_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q.line_index   <= line_q[IDX_W-1:0];
      out_data_q.line_matched <= matched;
      out_data_q.first_hit    <= first;
      out_data_q.line_empty   <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
  import lss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  reg_e             cfg_index = REG_PATTERN_LENGTH;
  logic [CFG_W-1:0] cfg_data  = '0;

  line_substring_search u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // search state mirrored on the testbench side
  logic [7:0]        pat_mem [PATTERN_MAX];
  logic [7:0]        window  [PATTERN_MAX];
  int unsigned       vis_count;
  int unsigned       cur_line;
  bit                line_hit;
  bit                line_cut;
  bit                line_open;
  bit                hit_done;
  logic [PLEN_W-1:0] plen_reg;
  logic [IDX_W-1:0]  start_reg;

  out_t line_reports [$];
  in_t  pending [$];

  int unsigned err_count    = 0;
  int unsigned beats_taken  = 0;
  int unsigned reports_seen = 0;
  int unsigned matched_seen = 0;
  int unsigned firsts_seen  = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          calm         = 1'b0;
  out_t        want;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 100) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // gap length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(12, 40);
  endfunction

  task automatic clear_line();
    foreach (window[k]) window[k] = 8'h00;
    vis_count = 0;
    line_hit  = 1'b0;
    line_cut  = 1'b0;
    line_open = 1'b0;
  endtask

  task automatic restart_text();
    clear_line();
    cur_line = 0;
    hit_done = 1'b0;
  endtask

  // close the current line and queue its result
  task automatic close_line();
    out_t rep;
    bit   matched;
    matched          = line_hit || (plen_reg == 0);
    rep.line_index   = cur_line[IDX_W-1:0];
    rep.line_matched = matched;
    rep.first_hit    = matched && !hit_done && (cur_line >= start_reg);
    rep.line_empty   = (vis_count == 0);
    if (rep.first_hit) hit_done = 1'b1;
    line_reports.push_back(rep);
    cur_line++;
    clear_line();
  endtask

  // advance the search by one accepted input beat
  task automatic advance_search(input in_t beat);
    int unsigned plen;
    int          k;
    bit          same;
    plen = (plen_reg > PATTERN_MAX) ? PATTERN_MAX : plen_reg;
    case (beat.command)
      CMD_PATTERN: begin
        pat_mem[beat.pattern_position] = beat.byte_value;
      end
      CMD_TEXT: begin
        if (cur_line < LINE_LIMIT) begin
          if (beat.byte_value == CH_NEWLINE) begin
            close_line();
          end else begin
            line_open = 1'b1;
            if (beat.byte_value == CH_RETURN || beat.byte_value == CH_NUL) begin
              line_cut = 1'b1;
            end else if (!line_cut) begin
              // newest visible byte sits in slot zero
              for (k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
              window[0] = beat.byte_value;
              if (vis_count < PATTERN_MAX) vis_count++;
              if (plen != 0 && vis_count >= plen) begin
                same = 1'b1;
                for (k = 0; k < plen; k++) begin
                  if (window[k] != pat_mem[plen-1-k]) same = 1'b0;
                end
                if (same) line_hit = 1'b1;
              end
            end
          end
        end
      end
      CMD_END: begin
        if (line_open && cur_line < LINE_LIMIT) close_line();
        restart_text();
      end
      default: begin
        restart_text();
      end
    endcase
  endtask

  // input driver: take the accepted beat, then present the next one or a gap
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        advance_search(in_data);
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_data  <= pending.pop_front();
          in_valid <= 1'b1;
          gap_left = calm ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: compare each result beat, then pick the next stall segment
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (line_reports.size() == 0) begin
          report_mismatch($sformatf("result beat for line %0d with no line pending",
                                    out_data.line_index));
        end else begin
          want = line_reports.pop_front();
          reports_seen++;
          if (want.line_matched) matched_seen++;
          if (want.first_hit) firsts_seen++;
          if (out_data.line_index !== want.line_index)
            report_mismatch($sformatf("line %0d: line_index got %0d",
                                      want.line_index, out_data.line_index));
          if (out_data.line_matched !== want.line_matched)
            report_mismatch($sformatf("line %0d: line_matched got %b want %b",
                                      want.line_index, out_data.line_matched,
                                      want.line_matched));
          if (out_data.first_hit !== want.first_hit)
            report_mismatch($sformatf("line %0d: first_hit got %b want %b",
                                      want.line_index, out_data.first_hit, want.first_hit));
          if (out_data.line_empty !== want.line_empty)
            report_mismatch($sformatf("line %0d: line_empty got %b want %b",
                                      want.line_index, out_data.line_empty,
                                      want.line_empty));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 2) == 0);
        stall_left = idle_len();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_beat(input cmd_e c, input logic [7:0] b,
                           input logic [PTR_W-1:0] pos);
    in_t beat;
    beat.command          = c;
    beat.byte_value       = b;
    beat.pattern_position = pos;
    pending.push_back(beat);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      push_beat(CMD_TEXT, s[i], PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
    end
  endtask

  // text byte drawn mostly from the pattern alphabet
  function automatic logic [7:0] text_char(input bit long_mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (long_mode) return (r < 99) ? "a" : "b";
    if (r < 45) return "a";
    if (r < 85) return "b";
    if (r < 93) return "c";
    return 8'($urandom_range(0, 255));
  endfunction

  // random lines with a fresh pattern, plus rewrites, ends, restarts and noise
  task automatic random_fill(input bit long_mode, input int unsigned plen,
                             input int unsigned budget);
    int unsigned made;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    made = 0;
    if (long_mode) begin
      for (k = 0; k < PATTERN_MAX; k++) push_beat(CMD_PATTERN, "a", PTR_W'(k));
    end else begin
      for (k = 0; k < plen; k++) push_beat(CMD_PATTERN, text_char(1'b0) & 8'h63, PTR_W'(k));
    end
    while (made < budget) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        len = long_mode ? $urandom_range(40, 80) : $urandom_range(0, 12);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 49) == 0)
            push_beat(CMD_TEXT, $urandom_range(0, 1) ? CH_RETURN : CH_NUL,
                      PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
          else
            push_beat(CMD_TEXT, text_char(long_mode),
                      PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
        end
        made += len;
        if ($urandom_range(0, 9) != 0) begin
          push_beat(CMD_TEXT, CH_NEWLINE, PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
          made++;
        end
      end else if (r < 80) begin
        // pattern slot rewritten in the middle of a line
        push_beat(CMD_PATTERN,
                  (!long_mode && $urandom_range(0, 1)) ? 8'($urandom_range(0, 255))
                                                       : text_char(long_mode),
                  PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
        made++;
      end else if (r < 85) begin
        push_beat(CMD_END, 8'($urandom_range(0, 255)),
                  PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
        made++;
      end else if (r < 89) begin
        push_beat(CMD_RESTART, 8'($urandom_range(0, 255)),
                  PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
        made++;
      end else begin
        push_beat(CMD_TEXT, 8'($urandom_range(0, 255)),
                  PTR_W'($urandom_range(0, PATTERN_MAX - 1)));
        made++;
      end
    end
  endtask

  // wait until every beat is in and every result is out
  task automatic settle();
    while (pending.size() != 0 || in_valid || line_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PATTERN_LENGTH) plen_reg = val[PLEN_W-1:0];
    else start_reg = val[IDX_W-1:0];
  endtask

  task automatic run_phase(input int unsigned plen, input int unsigned first_line,
                           input bit long_mode, input bit quiet, input int unsigned budget);
    settle();
    write_reg(REG_PATTERN_LENGTH, CFG_W'(plen));
    write_reg(REG_FIRST_LINE, CFG_W'(first_line));
    calm = quiet;
    random_fill(long_mode, plen, budget);
  endtask

  initial begin
    int unsigned k;
    restart_text();
    plen_reg  = '0;
    start_reg = '0;
    foreach (pat_mem[i]) pat_mem[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_PATTERN_LENGTH, CFG_W'(0));
    write_reg(REG_FIRST_LINE, CFG_W'(0));

    // every slot loaded up front, repeating a b c
    for (k = 0; k < PATTERN_MAX; k++) push_beat(CMD_PATTERN, 8'h61 + 8'(k % 3), PTR_W'(k));

    // empty pattern: every line matches, empty and hidden lines, end and restart
    push_text("\n");
    push_beat(CMD_TEXT, 8'hFF, '1);
    push_beat(CMD_TEXT, 8'h01, '0);
    push_text("\n");
    push_beat(CMD_TEXT, CH_RETURN, '0);
    push_text("ab\n");
    push_beat(CMD_TEXT, CH_NUL, '1);
    push_text("q\n");
    push_text("z");
    push_beat(CMD_END, 8'hFF, '1);
    push_beat(CMD_END, 8'h00, '0);
    push_text("\n");
    push_beat(CMD_RESTART, 8'h5A, 6'h15);

    // three byte pattern: hit before start line, hidden tail, mid line rewrite
    settle();
    write_reg(REG_PATTERN_LENGTH, CFG_W'(3));
    write_reg(REG_FIRST_LINE, CFG_W'(1));
    push_text("xabcx\n");
    push_text("ab\rabc\n");
    push_text("zabc\n");
    push_text("abc\n");
    push_text("ab");
    push_beat(CMD_PATTERN, "d", PTR_W'(2));
    push_text("d\n");
    push_beat(CMD_PATTERN, "c", PTR_W'(2));
    push_text("ab");
    push_beat(CMD_END, 8'hFF, '1);

    // random phases over short, long and oversized patterns
    run_phase(1,    0,    1'b0, 1'b0, 30);
    run_phase(2,    3,    1'b0, 1'b1, 30);
    run_phase(3,    0,    1'b0, 1'b0, 30);
    run_phase(4,    7,    1'b0, 1'b0, 30);
    run_phase(0,    2,    1'b0, 1'b1, 25);
    run_phase(64,   0,    1'b1, 1'b0, 50);
    run_phase(100,  1,    1'b1, 1'b0, 40);
    run_phase(127,  0,    1'b1, 1'b1, 40);
    run_phase(2,    4095, 1'b0, 1'b0, 25);
    settle();

    $display("covered %0d input beats and %0d line results, %0d matched, %0d first hits",
             beats_taken, reports_seen, matched_seen, firsts_seen);
    $display("pattern lengths 0 to 127, start lines 0 to 4095, hidden tails and rewrites");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/lss_pkg.sv
rtl/core/lss_cell.sv
rtl/core/line_substring_search.sv
verif/tb.sv
